// ----- hdl/phe_pkg.sv -----
// shared constants and control types of the pulse height extractor
package phe_pkg;

	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_MAX_BASELINE = 1024;
	localparam int DEF_FRAC_BITS = 8;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_BASELINE_COUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEGATIVE_PULSE = 1'd1;

	localparam logic [CFG_DATA_W-1:0] BASELINE_COUNT_RESET = 11'd16;

	typedef struct packed {
		logic take;
		logic div_start;
		logic base_load;
		logic out_load;
		logic clear;
	} phe_cmd_t;

	typedef struct packed {
		logic base_phase;
		logic base_end;
		logic div_done;
	} phe_status_t;

endpackage

// ----- hdl/phe_div.sv -----
// iterative restoring divider with floor rounding for signed dividends
module phe_div #(
	parameter int DVD_W = 35,
	parameter int DSR_W = 11,
	parameter int QUO_W = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0]        divisor,
	output logic                    done,
	output logic signed [QUO_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;

	logic [DVD_W-1:0] mag;
	logic [DSR_W:0]   shifted;
	logic [DSR_W:0]   trial;
	logic             fits;
	logic [DVD_W-1:0] fixed;

	always_comb begin
		mag = dividend[DVD_W-1] ? DVD_W'(~dividend + DVD_W'(1)) : DVD_W'(dividend);
		shifted = {rem_q, quo_q[DVD_W-1]};
		fits = shifted >= {1'b0, dsr_q};
		trial = shifted - {1'b0, dsr_q};
		// negative: -(q + (rem != 0)) = ~q + (rem == 0)
		fixed = neg_q ? DVD_W'(~quo_q + DVD_W'(rem_q == '0)) : quo_q;
	end

	assign done = busy_q && (step_q == '0);
	assign quotient = signed'(fixed[QUO_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= dividend[DVD_W-1];
			dsr_q <= divisor;
		end else if (busy_q && step_q != '0) begin
			rem_q <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

endmodule

// ----- hdl/phe_datapath.sv -----
// datapath: config registers, baseline sum, peak tracking, divider and result register
module phe_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_BASELINE = 1024,
	parameter int FRAC_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [phe_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [phe_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  phe_pkg::phe_cmd_t                     cmd,
	output phe_pkg::phe_status_t                  status,
	output logic [SAMPLE_BITS+FRAC_BITS-1:0]      height,
	output logic                                  short_record
);

	import phe_pkg::*;

	localparam int CNT_W = $clog2(MAX_BASELINE + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int LVL_W = SAMPLE_BITS + FRAC_BITS;
	localparam int DVD_W = SUM_W + FRAC_BITS;

	logic [CFG_DATA_W-1:0]   cfg_cnt_q;
	logic                    cfg_neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        act_cnt_q;
	logic                    act_neg_q;
	logic signed [LVL_W-1:0] base_q;
	logic signed [LVL_W-1:0] peak_q;
	logic [LVL_W-1:0]        height_q;
	logic                    short_q;

	logic [CNT_W-1:0]        cfg_eff;
	logic [CNT_W-1:0]        eff_cnt;
	logic                    eff_neg;
	logic [CNT_W-1:0]        cnt_inc;
	logic                    base_phase;
	logic signed [LVL_W-1:0] scaled;
	logic                    better;
	logic signed [LVL_W-1:0] peak_new;
	logic signed [LVL_W:0]   diff;
	logic [LVL_W-1:0]        height_new;
	logic signed [DVD_W-1:0] dividend;
	logic signed [LVL_W-1:0] quotient;
	logic                    div_done;

	always_comb begin
		if (cfg_cnt_q == '0) begin
			cfg_eff = CNT_W'(1);
		end else if (32'(cfg_cnt_q) > 32'(MAX_BASELINE)) begin
			cfg_eff = CNT_W'(MAX_BASELINE);
		end else begin
			cfg_eff = CNT_W'(cfg_cnt_q);
		end
		eff_cnt = (cnt_q == '0) ? cfg_eff : act_cnt_q;
		eff_neg = (cnt_q == '0) ? cfg_neg_q : act_neg_q;
		cnt_inc = cnt_q + CNT_W'(1);
		base_phase = cnt_q < eff_cnt;
		scaled = LVL_W'(sample) <<< FRAC_BITS;
		better = eff_neg ? (scaled < peak_q) : (scaled > peak_q);
		peak_new = (cmd.take && !base_phase && better) ? scaled : peak_q;
		if (eff_neg) begin
			diff = (LVL_W+1)'(base_q) - (LVL_W+1)'(peak_new);
		end else begin
			diff = (LVL_W+1)'(peak_new) - (LVL_W+1)'(base_q);
		end
		height_new = diff[LVL_W] ? '0 : diff[LVL_W-1:0];
		dividend = DVD_W'(sum_q) <<< FRAC_BITS;
	end

	assign status.base_phase = base_phase;
	assign status.base_end = (cnt_inc == eff_cnt);
	assign status.div_done = div_done;
	assign height = height_q;
	assign short_record = short_q;

	phe_div #(
		.DVD_W(DVD_W),
		.DSR_W(CNT_W),
		.QUO_W(LVL_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (act_cnt_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cnt_q <= BASELINE_COUNT_RESET;
			cfg_neg_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BASELINE_COUNT: cfg_cnt_q <= cfg_data;
				CFG_NEGATIVE_PULSE: cfg_neg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.take && base_phase) begin
			cnt_q <= cnt_inc;
			sum_q <= sum_q + SUM_W'(sample);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && cnt_q == '0) begin
			act_cnt_q <= cfg_eff;
			act_neg_q <= cfg_neg_q;
		end
		if (cmd.base_load) begin
			base_q <= quotient;
			peak_q <= quotient;
		end else begin
			peak_q <= peak_new;
		end
		if (cmd.out_load) begin
			short_q <= cmd.take && base_phase;
			height_q <= (cmd.take && base_phase) ? '0 : height_new;
		end
	end

endmodule

// ----- hdl/phe_ctrl.sv -----
// controller state machine: record sequencing, divider hand-off and result handshake
module phe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  phe_pkg::phe_status_t status,
	output phe_pkg::phe_cmd_t    cmd
);

	import phe_pkg::*;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       last_pend_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_RUN) || (in_last && !out_free);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_next = state_q;
		case (state_q)
			ST_RUN: begin
				cmd.take = in_valid && !in_stall;
				if (cmd.take) begin
					if (status.base_phase && status.base_end) begin
						state_next = ST_LOAD;
					end else if (in_last) begin
						cmd.out_load = 1'b1;
						cmd.clear = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_next = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) begin
					cmd.base_load = 1'b1;
					state_next = last_pend_q ? ST_FIN : ST_RUN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear = 1'b1;
					state_next = ST_RUN;
				end
			end
			default: state_next = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			last_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.take) begin
				last_pend_q <= in_last;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/pulse_height_extract.sv -----
// top level of the baseline-subtracted pulse height extractor
// Input channel (in_valid, in_stall, sample, last) carries one signed ADC sample
// per transfer; last marks the final sample of a record. The output channel
// (out_valid, out_stall, height, short_record) gives one result per record,
// taken from an output register that is loaded at the transfer of the last sample.
// The first baseline_count samples of a record are summed; after the sample that
// completes that sum, a restoring divider (one quotient bit per cycle) forms the
// Q.FRAC_BITS baseline, and in_stall stays high while the controller starts the
// divider and waits for its result. All other samples flow without a stall. If that
// sample is also the last one, the result is loaded once the divider is done and
// the output register is free. A last sample is held off by in_stall while a
// result still waits in the output register under out_stall; other samples keep
// flowing. The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready; register values are latched at the first sample of a record.
// Reset clears the record state and loads baseline_count 16, positive pulses.
module pulse_height_extract #(
	parameter int SAMPLE_BITS = phe_pkg::DEF_SAMPLE_BITS,
	parameter int MAX_BASELINE = phe_pkg::DEF_MAX_BASELINE,
	parameter int FRAC_BITS = phe_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [SAMPLE_BITS+FRAC_BITS-1:0] height,
	output logic                             short_record,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [phe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [phe_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import phe_pkg::*;

	phe_cmd_t    cmd;
	phe_status_t status;

	assign cfg_ready = 1'b1;

	phe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (last),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	phe_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_BASELINE(MAX_BASELINE),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.cmd         (cmd),
		.status      (status),
		.height      (height),
		.short_record(short_record)
	);

endmodule

// ----- tb/pulse_height_extract_test.sv -----
// testbench of the pulse height extractor: directed and random records checked against a predictor
`timescale 1ns / 1ps

module pulse_height_extract_test;
	import phe_pkg::*;

	localparam int SAMPLE_W = DEF_SAMPLE_BITS;
	localparam int HEIGHT_W = DEF_SAMPLE_BITS + DEF_FRAC_BITS;
	localparam longint HEIGHT_TOP = (longint'(1) << HEIGHT_W) - 1;
	localparam int SETTLE_CYCLES = 48;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 30;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic                short_record;
	} height_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;
	logic                       out_valid;
	logic                       out_stall;
	logic [HEIGHT_W-1:0]        height;
	logic                       short_record;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	pulse_height_extract uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.height(height),
		.short_record(short_record),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register copies and record state of the predictor
	logic [CFG_DATA_W-1:0]      set_count;
	logic                       set_negative;
	logic [CFG_DATA_W-1:0]      rec_count;
	logic                       rec_negative;
	logic [CFG_DATA_W-1:0]      rec_seen;
	logic signed [25:0]         rec_sum;
	logic signed [HEIGHT_W-1:0] rec_base;
	logic signed [HEIGHT_W-1:0] rec_peak;

	height_result_t pending_heights[$];
	int mismatches;
	int sender_idle_pct;
	int receiver_stall_pct;
	int samples_sent;
	int quiet_cycles;

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	function automatic longint floor_div(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip_sample(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic clear_pulse_record();
		rec_seen = '0;
		rec_sum = '0;
		rec_base = '0;
		rec_peak = '0;
		rec_count = 11'd1;
		rec_negative = 1'b0;
	endtask

	task automatic predict_height(input logic signed [SAMPLE_W-1:0] s, input logic l);
		longint scaled;
		longint quot;
		longint diff;
		height_result_t res;
		scaled = longint'(s) * (longint'(1) << DEF_FRAC_BITS);
		if (rec_seen == 0) begin
			if (set_count == 0)
				rec_count = 11'd1;
			else if (set_count > DEF_MAX_BASELINE)
				rec_count = CFG_DATA_W'(DEF_MAX_BASELINE);
			else
				rec_count = set_count;
			rec_negative = set_negative;
		end
		if (rec_seen < rec_count) begin
			rec_sum = rec_sum + s;
			rec_seen = rec_seen + 11'd1;
			if (rec_seen == rec_count) begin
				quot = floor_div(longint'(rec_sum) * (longint'(1) << DEF_FRAC_BITS),
					longint'(rec_count));
				rec_base = quot[HEIGHT_W-1:0];
				rec_peak = quot[HEIGHT_W-1:0];
			end
		end else if (rec_negative) begin
			if (scaled < longint'(rec_peak))
				rec_peak = scaled[HEIGHT_W-1:0];
		end else begin
			if (scaled > longint'(rec_peak))
				rec_peak = scaled[HEIGHT_W-1:0];
		end
		if (l) begin
			if (rec_seen < rec_count) begin
				res.height = '0;
				res.short_record = 1'b1;
			end else begin
				diff = rec_negative ? longint'(rec_base) - longint'(rec_peak)
					: longint'(rec_peak) - longint'(rec_base);
				if (diff < 0)
					diff = 0;
				if (diff > HEIGHT_TOP)
					diff = HEIGHT_TOP;
				res.height = diff[HEIGHT_W-1:0];
				res.short_record = 1'b0;
			end
			pending_heights = {pending_heights, res};
			clear_pulse_record();
		end
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_height(s, l);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_BASELINE_COUNT)
			set_count = val;
		else if (idx == CFG_NEGATIVE_PULSE)
			set_negative = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_settings(input logic [CFG_DATA_W-1:0] count, input logic neg);
		logic [CFG_DATA_W-1:0] neg_word;
		neg_word = CFG_DATA_W'($urandom_range(2047));
		neg_word[0] = neg;
		write_register(CFG_BASELINE_COUNT, count);
		write_register(CFG_NEGATIVE_PULSE, neg_word);
	endtask

	// sender pauses until every result is in and the divider has settled
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_heights.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_height_result();
		height_result_t want;
		if (pending_heights.size() == 0) begin
			$display("%0t: unexpected result height %0d short_record %0b",
				$time, height, short_record);
			mismatches++;
		end else begin
			want = pending_heights.pop_front();
			if (height !== want.height) begin
				$display("%0t: height expected %0d actual %0d", $time, want.height, height);
				mismatches++;
			end
			if (short_record !== want.short_record) begin
				$display("%0t: short_record expected %0b actual %0b",
					$time, want.short_record, short_record);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_height_result();
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_default_record();
		int i;
		for (i = 0; i < 15; i++)
			send_sample((i % 2) ? 16'sh7fff : 16'sh8000, 1'b0);
		send_sample(-16'sd3, 1'b1);
		drain_results();
	endtask

	task automatic test_short_and_exact();
		write_settings(11'd2, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(-16'sd4, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sd7, 1'b1);
		drain_results();
	endtask

	task automatic test_negative_mode();
		write_settings(11'd2, 1'b1);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd2, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd100, 1'b1);
		drain_results();
	endtask

	task automatic test_count_zero();
		write_settings(11'd0, 1'b0);
		send_sample(16'sd3, 1'b0);
		send_sample(16'sd10, 1'b1);
		send_sample(-16'sd1, 1'b1);
		drain_results();
	endtask

	// settings written mid record apply only from the next record
	task automatic test_change_inside_record();
		write_settings(11'd3, 1'b0);
		send_sample(16'sd20, 1'b0);
		send_sample(16'sd21, 1'b0);
		drain_results();
		write_settings(11'd1, 1'b1);
		send_sample(16'sd22, 1'b0);
		send_sample(16'sd50, 1'b0);
		send_sample(-16'sd60, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(-16'sd9, 1'b1);
		drain_results();
	endtask

	// count above the maximum, lowest baseline and largest height
	task automatic test_count_extremes();
		int i;
		write_settings(11'd2047, 1'b0);
		for (i = 0; i < DEF_MAX_BASELINE; i++)
			send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		drain_results();
	endtask

	task automatic send_random_record(input int count);
		int len;
		int i;
		int offset;
		int noise;
		int kind;
		logic signed [SAMPLE_W-1:0] s;
		kind = $urandom_range(9);
		if (kind < 2 && count > 1)
			len = $urandom_range(1, count - 1);
		else if (kind < 4)
			len = count;
		else
			len = count + $urandom_range(1, 24);
		offset = $urandom_range(60000) - 30000;
		for (i = 0; i < len; i++) begin
			noise = $urandom_range(200) - 100;
			if (i >= count && $urandom_range(3) == 0)
				noise = noise * $urandom_range(1, 40);
			case ($urandom_range(9))
				0: s = SAMPLE_W'($urandom_range(65535));
				1: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				default: s = clip_sample(offset + noise);
			endcase
			send_sample(s, i == len - 1);
		end
	endtask

	task automatic test_random_records();
		int phase;
		int start;
		int records;
		int count;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 48; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 48; end
				default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
			endcase
			start = samples_sent;
			while (samples_sent - start < PHASE_ITEMS) begin
				case ($urandom_range(19))
					0: count = 0;
					1: count = $urandom_range(13, 64);
					default: count = $urandom_range(1, 12);
				endcase
				write_settings(CFG_DATA_W'(count), 1'($urandom_range(1)));
				if (count == 0)
					count = 1;
				for (records = $urandom_range(2, 6); records > 0; records--)
					send_random_record(count);
				drain_results();
			end
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		last = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		samples_sent = 0;
		quiet_cycles = 0;
		set_count = BASELINE_COUNT_RESET;
		set_negative = 1'b0;
		clear_pulse_record();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_record();
		test_short_and_exact();
		test_negative_mode();
		test_count_zero();
		test_change_inside_record();
		test_count_extremes();
		test_random_records();
		drain_results();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
